// ===== hw/rtl/rtsm_pkg.sv =====
// Package for the rule table state machine: codes, types and default sizes.
`default_nettype none
package rtsm_pkg;

	// fixed field widths of the input and result words
	localparam int CODE_W  = 4;
	localparam int EVENT_W = 8;

	// default sizes
	localparam int MAX_STATES_DEF = 16;
	localparam int MAX_RULES_DEF  = 32;
	localparam int EVENT_BITS_DEF = 8;

	// command codes
	typedef enum logic [1:0] {
		OP_ADD_STATE = 2'd0,
		OP_ADD_RULE  = 2'd1,
		OP_SET_STATE = 2'd2,
		OP_TRIGGER   = 2'd3
	} op_t;

	// classified command word as it sits in the queue
	typedef struct packed {
		op_t                 op;
		logic [CODE_W-1:0]   code;
		logic                code_ok;  // code below MAX_STATES
		logic [EVENT_W-1:0]  ev;       // already masked to EVENT_BITS
		logic [CODE_W-1:0]   from;
		logic [CODE_W-1:0]   to;
	} item_t;

	// queue head toward the back end
	typedef struct packed {
		logic  vld;
		item_t item;
	} q_head_t;

	// one result word
	typedef struct packed {
		logic              accepted;
		logic              left_valid;
		logic [CODE_W-1:0] left_state;
		logic              entered_valid;
		logic [CODE_W-1:0] entered_state;
		logic              changed_by_event;
		logic              current_valid;
		logic [CODE_W-1:0] current_now;
	} res_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_SCAN = 2'd1,
		B_DONE = 2'd2
	} back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rtsm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module rtsm_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rtsm_front.sv =====
// Front end: takes command words, classifies them and queues them for the back end.
`default_nettype none
module rtsm_front #(
	parameter int MAX_STATES = rtsm_pkg::MAX_STATES_DEF,
	parameter int EVENT_BITS = rtsm_pkg::EVENT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [rtsm_pkg::CODE_W-1:0]  state_code,
	input  wire logic [rtsm_pkg::EVENT_W-1:0] event_code,
	input  wire logic [rtsm_pkg::CODE_W-1:0]  from_state,
	input  wire logic [rtsm_pkg::CODE_W-1:0]  to_state,
	output rtsm_pkg::q_head_t                 head,
	input  wire logic                         pop
);
	import rtsm_pkg::*;

	localparam int EVB = (EVENT_BITS < EVENT_W) ? EVENT_BITS : EVENT_W;
	localparam int EVM = (1 << EVB) - 1;
	localparam logic [EVENT_W-1:0] EV_MASK = EVENT_W'(EVM);

	item_t      q_item_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// classify the incoming word
	always_comb begin
		cls.op      = op_t'(command);
		cls.code    = state_code;
		cls.code_ok = (9'(state_code) < 9'(MAX_STATES));
		cls.ev      = event_code & EV_MASK;
		cls.from    = from_state;
		cls.to      = to_state;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;

	// two entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			q_item_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign head.vld  = (cnt_q != 2'd0);
	assign head.item = q_item_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== hw/rtl/rtsm_back.sv =====
// Back end: holds the machine state and rule table, executes queued commands.
`default_nettype none
module rtsm_back #(
	parameter int MAX_STATES = rtsm_pkg::MAX_STATES_DEF,
	parameter int MAX_RULES  = rtsm_pkg::MAX_RULES_DEF,
	parameter int EVENT_BITS = rtsm_pkg::EVENT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtsm_pkg::q_head_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rtsm_pkg::res_t         res
);
	import rtsm_pkg::*;

	localparam int EVB    = (EVENT_BITS < EVENT_W) ? EVENT_BITS : EVENT_W;
	localparam int NUM_ST = (MAX_STATES < 16) ? MAX_STATES : 16;
	localparam int SIB    = $clog2(NUM_ST);
	localparam int AW     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW     = $clog2(MAX_RULES + 1);
	localparam int RW     = EVB + 2 * CODE_W;

	back_state_t       st_q, st_nx;
	logic [NUM_ST-1:0] present_q, present_nx;
	logic [CODE_W-1:0] cur_q, cur_nx;
	logic              have_q, have_nx;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic              chk_s1;
	logic              found_q;
	logic [CODE_W-1:0] tgt_q;
	logic              out_vld_q;
	res_t              res_q, res_nx;

	logic              full;
	logic              needs_scan;
	logic              issue;
	logic              match;
	logic              fin;
	logic              room;
	logic              go;
	logic [CODE_W-1:0] tgt;
	logic              rule_we;
	logic [RW-1:0]     rd_word;
	logic [EVB-1:0]    rd_ev;
	logic [CODE_W-1:0] rd_from;
	logic [CODE_W-1:0] rd_to;

	function automatic logic is_present(logic [CODE_W-1:0] c, logic [NUM_ST-1:0] pv);
		logic in_rng;
		in_rng = (9'(c) < 9'(MAX_STATES));
		return in_rng && pv[c[SIB-1:0]];
	endfunction

	// rule table
	rtsm_ram #(
		.DATA_W (RW),
		.DEPTH  (MAX_RULES),
		.ADDR_W (AW)
	) u_rules (
		.clk   (clk),
		.we    (rule_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({head.item.ev[EVB-1:0], head.item.from, head.item.to}),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_word)
	);

	assign rd_ev   = rd_word[RW-1 -: EVB];
	assign rd_from = rd_word[2*CODE_W-1 -: CODE_W];
	assign rd_to   = rd_word[CODE_W-1:0];

	assign full       = (cnt_q == CW'(MAX_RULES));
	assign needs_scan = (head.item.op == OP_TRIGGER) && have_q && (cnt_q != '0);
	assign match      = chk_s1 && (rd_ev == head.item.ev[EVB-1:0]) &&
	                    (rd_from == cur_q) && is_present(rd_to, present_q);
	assign room       = !out_vld_q || !out_stall;

	// sequencer next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			B_IDLE: begin
				if (head.vld && needs_scan) st_nx = B_SCAN;
			end
			B_SCAN: begin
				if (match || !issue) st_nx = B_DONE;
			end
			B_DONE: begin
				if (room) st_nx = B_IDLE;
			end
			default: st_nx = B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		issue = 1'b0;
		fin   = 1'b0;
		case (st_q)
			B_IDLE: fin = head.vld && !needs_scan && room;
			B_SCAN: issue = (idx_q < cnt_q);
			B_DONE: fin = room;
			default: begin
				issue = 1'b0;
				fin   = 1'b0;
			end
		endcase
	end

	assign pop     = fin;
	assign rule_we = fin && (head.item.op == OP_ADD_RULE) && !full;

	// command execution and result word
	always_comb begin
		present_nx = present_q;
		cur_nx     = cur_q;
		have_nx    = have_q;
		go         = 1'b0;
		tgt        = '0;
		res_nx     = '0;
		case (head.item.op)
			OP_ADD_STATE: begin
				if (head.item.code_ok && !present_q[head.item.code[SIB-1:0]]) begin
					present_nx[head.item.code[SIB-1:0]] = 1'b1;
					res_nx.accepted = 1'b1;
					if (!have_q) begin
						have_nx              = 1'b1;
						cur_nx               = head.item.code;
						res_nx.entered_valid = 1'b1;
						res_nx.entered_state = head.item.code;
					end
				end
			end
			OP_ADD_RULE: begin
				res_nx.accepted = !full;
			end
			OP_SET_STATE: begin
				go  = head.item.code_ok && present_q[head.item.code[SIB-1:0]];
				tgt = head.item.code;
			end
			OP_TRIGGER: begin
				go                      = (st_q == B_DONE) && found_q;
				tgt                     = tgt_q;
				res_nx.changed_by_event = go;
			end
			default: go = 1'b0;
		endcase
		if (go) begin
			res_nx.left_valid    = have_q;
			res_nx.left_state    = have_q ? cur_q : '0;
			res_nx.entered_valid = 1'b1;
			res_nx.entered_state = tgt;
			res_nx.accepted      = 1'b1;
			cur_nx               = tgt;
			have_nx              = 1'b1;
		end
		res_nx.current_valid = have_nx;
		res_nx.current_now   = have_nx ? cur_nx : '0;
	end

	// control and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			present_q <= '0;
			cur_q     <= '0;
			have_q    <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			chk_s1    <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (fin) begin
				present_q <= present_nx;
				cur_q     <= cur_nx;
				have_q    <= have_nx;
				out_vld_q <= 1'b1;
				if (rule_we) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			// scan pointer and compare stage
			if (st_q == B_IDLE) begin
				idx_q   <= '0;
				chk_s1  <= 1'b0;
				found_q <= 1'b0;
			end else if (st_q == B_SCAN) begin
				chk_s1 <= issue && !match;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// target of the hit rule
	always_ff @(posedge clk) begin
		if ((st_q == B_SCAN) && match) begin
			tgt_q <= rd_to;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res_nx;
		end
	end

	assign out_valid = out_vld_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rule_table_state_machine.sv =====
// Top level of the programmable rule table state machine.
// Input channel (in_valid/in_stall) carries command words: add state, add rule,
// set current state, trigger event. A word is taken when in_valid is high and
// in_stall is low. A two word queue sits between the front end and the back end.
// Output channel (out_valid/out_stall) returns exactly one result word per
// command, in order, held in a register until taken.
// Add state, add rule and set state words go through the queue to the result
// register without a scan, so such words stream at one per cycle while out_stall
// is low. A trigger with a current state and a non-empty table scans the rule
// RAM one rule per cycle through its registered read port, first hit wins; a
// miss reads every rule below the rule count. Commands run one at a
// time in the back end; the front end keeps taking words while the queue has room.
// Reset clears present states, rule count and current state; no clearing pass
// is needed since only rules below the count are ever read.
// While out_stall is high the result word holds, the back end waits, and the
// queue fills and then raises in_stall.
`default_nettype none
module rule_table_state_machine #(
	parameter int MAX_STATES = rtsm_pkg::MAX_STATES_DEF,
	parameter int MAX_RULES  = rtsm_pkg::MAX_RULES_DEF,
	parameter int EVENT_BITS = rtsm_pkg::EVENT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [rtsm_pkg::CODE_W-1:0]  state_code,
	input  wire logic [rtsm_pkg::EVENT_W-1:0] event_code,
	input  wire logic [rtsm_pkg::CODE_W-1:0]  from_state,
	input  wire logic [rtsm_pkg::CODE_W-1:0]  to_state,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              accepted,
	output logic                              left_valid,
	output logic [rtsm_pkg::CODE_W-1:0]       left_state,
	output logic                              entered_valid,
	output logic [rtsm_pkg::CODE_W-1:0]       entered_state,
	output logic                              changed_by_event,
	output logic                              current_valid,
	output logic [rtsm_pkg::CODE_W-1:0]       current_now
);
	import rtsm_pkg::*;

	q_head_t head;
	logic    pop;
	res_t    res;

	rtsm_front #(
		.MAX_STATES (MAX_STATES),
		.EVENT_BITS (EVENT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.state_code (state_code),
		.event_code (event_code),
		.from_state (from_state),
		.to_state   (to_state),
		.head       (head),
		.pop        (pop)
	);

	rtsm_back #(
		.MAX_STATES (MAX_STATES),
		.MAX_RULES  (MAX_RULES),
		.EVENT_BITS (EVENT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// unpack the result word
	assign accepted         = res.accepted;
	assign left_valid       = res.left_valid;
	assign left_state       = res.left_state;
	assign entered_valid    = res.entered_valid;
	assign entered_state    = res.entered_state;
	assign changed_by_event = res.changed_by_event;
	assign current_valid    = res.current_valid;
	assign current_now      = res.current_now;

	// a refused command never moves the machine
	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> !left_valid && !entered_valid)
		else $error("refused command reports a state change");

	// a leave always comes with an enter
	a_leave_enter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && left_valid |-> entered_valid)
		else $error("leave without enter");

	// an event transition is a full, accepted change of state
	a_event_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && changed_by_event |-> accepted && left_valid && entered_valid)
		else $error("event transition incomplete");

	// the entered state is the new current state
	a_enter_current: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entered_valid |-> current_valid && (current_now == entered_state))
		else $error("entered state differs from current state");

endmodule
`default_nettype wire
